// File: rtl/core/tovn_pkg.sv
// ----------------------------------------------------------------------------
// tovn_pkg
// Shared constants and helpers for the two-octave hashed value noise block:
// hash multipliers, smoothstep bias, lattice row stride and the Q8 blend.
// ----------------------------------------------------------------------------
package tovn_pkg;

  // default lattice shifts for the two octaves
  localparam int COARSE_SHIFT_DEF = 6;
  localparam int FINE_SHIFT_DEF   = 5;

  // integer hash multipliers
  localparam logic [31:0] HASH_MUL_A = 32'h7feb352d;
  localparam logic [31:0] HASH_MUL_B = 32'h846ca68b;

  // row stride of the lattice hash input
  localparam int HASH_ROW_MUL = 19;

  // smoothstep t*t*(EASE_BIAS - 2t) >> 16
  localparam logic [9:0] EASE_BIAS = 10'd768;

  // corner index within one octave
  localparam int CORNER_TL = 0;  // left column, top row
  localparam int CORNER_BL = 1;  // left column, bottom row
  localparam int CORNER_TR = 2;  // right column, top row
  localparam int CORNER_BR = 3;  // right column, bottom row
  localparam int NUM_CORNERS = 4;
  localparam int NUM_OCTAVES = 2;

  // first fold of the hash, ahead of the first multiply
  function automatic logic [31:0] hash_fold16(input logic [31:0] v);
    return v ^ (v >> 16);
  endfunction

  // second fold of the hash, ahead of the second multiply
  function automatic logic [31:0] hash_fold15(input logic [31:0] v);
    return v ^ (v >> 15);
  endfunction

  // final fold, low byte only
  function automatic logic [7:0] hash_low8(input logic [31:0] v);
    return v[7:0] ^ v[23:16];
  endfunction

  // lo + (hi - lo) * frac / 256, division truncating toward zero
  function automatic logic [7:0] lerp_q8(input logic [7:0] lo,
                                         input logic [7:0] hi,
                                         input logic [7:0] frac);
    logic signed [8:0]  diff;
    logic signed [17:0] prod;
    logic signed [17:0] adj;
    logic signed [9:0]  step;
    logic [9:0]         sum;
    diff = $signed({1'b0, hi}) - $signed({1'b0, lo});
    prod = diff * $signed({1'b0, frac});
    // bias negative products so the arithmetic shift rounds toward zero
    adj  = prod + (prod[17] ? 18'sd255 : 18'sd0);
    step = 10'(adj >>> 8);
    sum  = {2'b00, lo} + $unsigned(step);
    return sum[7:0];
  endfunction

endpackage

// File: rtl/core/two_octave_value_noise_top.sv
// Pipeline: the edge that takes the request loads stage 1; density_o and valid_o
//   come from the result register, which is stage 6.
// Throughput: one request per clock; busy_o stays low, the six-stage pipeline
//   with its two hash multiplies per corner sets the depth, not the rate.
// Reset: rst_ni clears only the stage valid bits; payload registers hold junk.
// ----------------------------------------------------------------------------
// two_octave_value_noise_top
// Hashed 2-D value noise over two octaves with Q8 smoothstep blending.
// Each octave hashes four lattice corners, blends vertically then
// horizontally, and the octaves mix as (3*coarse + fine) / 4.
// ----------------------------------------------------------------------------
module two_octave_value_noise_top #(
  parameter int COARSE_SHIFT = tovn_pkg::COARSE_SHIFT_DEF,
  parameter int FINE_SHIFT   = tovn_pkg::FINE_SHIFT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [16:0] x_pos_q8_i,
  input  logic [7:0]  row_i,
  output logic        valid_o,
  output logic [7:0]  density_o
);

  localparam int NumOct = tovn_pkg::NUM_OCTAVES;
  localparam int NumCor = tovn_pkg::NUM_CORNERS;
  localparam int MinShift = (COARSE_SHIFT < FINE_SHIFT) ? COARSE_SHIFT : FINE_SHIFT;
  // column plus row times stride stays below 20 * lattice width
  localparam int HashInW = $clog2(20 * (256 >> MinShift));

  // pipeline valid bits
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q, out_valid_q;

  // stage 1: hash inputs and raw fractions
  logic [HashInW-1:0] hash_in_d [NumOct][NumCor];
  logic [HashInW-1:0] hash_in_q [NumOct][NumCor];
  logic [7:0]         ty_d [NumOct];
  logic [7:0]         tx_d [NumOct];
  logic [7:0]         ty_q [NumOct];
  logic [7:0]         tx_q [NumOct];

  // stage 2: first hash product, squared fractions
  logic [31:0] mul1_q [NumOct][NumCor];
  logic [15:0] ty_sq_q [NumOct];
  logic [15:0] tx_sq_q [NumOct];
  logic [7:0]  ty2_q [NumOct];
  logic [7:0]  tx2_q [NumOct];

  // stage 3: second hash product, eased fractions
  logic [31:0] mul2_q [NumOct][NumCor];
  logic [7:0]  fy_q [NumOct];
  logic [7:0]  fx3_q [NumOct];
  logic [7:0]  corner_w [NumOct][NumCor];

  // stage 4: vertical blends
  logic [7:0] left_q [NumOct];
  logic [7:0] right_q [NumOct];
  logic [7:0] fx4_q [NumOct];

  // stage 5: octave values
  logic [7:0] oct_q [NumOct];

  // stage 6: mixed density
  logic [7:0] density_q;

  // lattice addressing per octave
  for (genvar g = 0; g < NumOct; g++) begin : g_oct
    localparam int Sh = (g == 0) ? COARSE_SHIFT : FINE_SHIFT;
    localparam logic [16:0] ColMask = 17'((256 >> Sh) - 1);
    localparam logic [7:0] FracMask = 8'((1 << Sh) - 1);
    localparam logic [HashInW-1:0] RowMul = HashInW'(tovn_pkg::HASH_ROW_MUL);

    logic [16:0]        cell_col;
    logic [16:0]        col_l;
    logic [16:0]        col_r;
    logic [7:0]         cell_row;
    logic [8:0]         cell_row_n;
    logic [HashInW-1:0] row_top;
    logic [HashInW-1:0] row_bot;

    assign cell_col   = x_pos_q8_i >> (Sh + 8);
    assign col_l      = cell_col & ColMask;
    assign col_r      = (cell_col + 17'd1) & ColMask;
    assign cell_row   = row_i >> Sh;
    assign cell_row_n = {1'b0, cell_row} + 9'd1;
    assign row_top    = HashInW'(cell_row) * RowMul;
    assign row_bot    = HashInW'(cell_row_n) * RowMul;

    assign hash_in_d[g][tovn_pkg::CORNER_TL] = HashInW'(col_l) + row_top;
    assign hash_in_d[g][tovn_pkg::CORNER_BL] = HashInW'(col_l) + row_bot;
    assign hash_in_d[g][tovn_pkg::CORNER_TR] = HashInW'(col_r) + row_top;
    assign hash_in_d[g][tovn_pkg::CORNER_BR] = HashInW'(col_r) + row_bot;

    // Q8 fraction within the cell
    assign ty_d[g] = 8'((row_i & FracMask) << (8 - Sh));
    assign tx_d[g] = 8'(x_pos_q8_i >> Sh);

    // corner values out of the second hash product
    for (genvar k = 0; k < NumCor; k++) begin : g_cor
      assign corner_w[g][k] = tovn_pkg::hash_low8(mul2_q[g][k]);
    end
  end

  // valid bits advance every cycle, no backpressure
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= start_i && !busy_o;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      s5_valid_q  <= s4_valid_q;
      out_valid_q <= s5_valid_q;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    for (int g = 0; g < NumOct; g++) begin
      // stage 1
      ty_q[g] <= ty_d[g];
      tx_q[g] <= tx_d[g];
      // stage 2
      ty_sq_q[g] <= 16'(ty_q[g]) * 16'(ty_q[g]);
      tx_sq_q[g] <= 16'(tx_q[g]) * 16'(tx_q[g]);
      ty2_q[g]   <= ty_q[g];
      tx2_q[g]   <= tx_q[g];
      // stage 3: smoothstep
      fy_q[g]  <= 8'((26'(ty_sq_q[g]) *
                      26'(tovn_pkg::EASE_BIAS - {1'b0, ty2_q[g], 1'b0})) >> 16);
      fx3_q[g] <= 8'((26'(tx_sq_q[g]) *
                      26'(tovn_pkg::EASE_BIAS - {1'b0, tx2_q[g], 1'b0})) >> 16);
      // stage 4: vertical blend of both columns
      left_q[g]  <= tovn_pkg::lerp_q8(corner_w[g][tovn_pkg::CORNER_TL],
                                      corner_w[g][tovn_pkg::CORNER_BL], fy_q[g]);
      right_q[g] <= tovn_pkg::lerp_q8(corner_w[g][tovn_pkg::CORNER_TR],
                                      corner_w[g][tovn_pkg::CORNER_BR], fy_q[g]);
      fx4_q[g]   <= fx3_q[g];
      // stage 5: horizontal blend
      oct_q[g] <= tovn_pkg::lerp_q8(left_q[g], right_q[g], fx4_q[g]);
      for (int k = 0; k < NumCor; k++) begin
        hash_in_q[g][k] <= hash_in_d[g][k];
        mul1_q[g][k] <= tovn_pkg::hash_fold16(32'(hash_in_q[g][k])) * tovn_pkg::HASH_MUL_A;
        mul2_q[g][k] <= tovn_pkg::hash_fold15(mul1_q[g][k]) * tovn_pkg::HASH_MUL_B;
      end
    end
    // stage 6: octave mix
    density_q <= 8'(((10'(oct_q[0]) * 10'd3) + 10'(oct_q[1])) >> 2);
  end

  assign busy_o    = 1'b0;
  assign valid_o   = out_valid_q;
  assign density_o = density_q;

  // every result traces back to an earlier request
  a_result_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i, 6))
    else $error("result strobe without a matching request");

  // the octave stage (stage 5) always hands its item to the output register
  a_tail_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s5_valid_q |=> valid_o)
    else $error("item lost between octave stage and output");

  // equal octaves mix to the same value
  a_equal_octaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s5_valid_q && (oct_q[0] == oct_q[1]) |=> density_o == $past(oct_q[0]))
    else $error("octave mix wrong for equal octaves");

  // zero vertical fraction leaves the top-left corner unchanged
  a_zero_fy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q && (fy_q[0] == 8'd0) |=>
      left_q[0] == $past(corner_w[0][tovn_pkg::CORNER_TL]))
    else $error("vertical blend wrong at zero fraction");

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for two_octave_value_noise_top. A queue of pixel
// requests feeds a falling-edge driver; a rising-edge monitor predicts the
// two-octave density of every accepted request and checks each strobed result
// in order against the oldest prediction. Sender gaps vary by phase.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COARSE_SH = tovn_pkg::COARSE_SHIFT_DEF;
  localparam int FINE_SH   = tovn_pkg::FINE_SHIFT_DEF;
  localparam int SETTLE_CYCLES = 10;

  typedef struct {
    logic [16:0] x;
    logic [7:0]  row;
    int unsigned gap_pct;
    bit          drain;
  } pixel_req_t;

  typedef struct {
    logic [16:0] x;
    logic [7:0]  row;
    logic [7:0]  density;
  } density_exp_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [16:0] x_pos_q8_i;
  logic [7:0]  row_i;
  logic        valid_o;
  logic [7:0]  density_o;

  pixel_req_t   pending_pixels[$];
  density_exp_t expected_density[$];
  bit           req_taken;
  int unsigned  mismatch_count;

  two_octave_value_noise_top #(
    .COARSE_SHIFT(COARSE_SH),
    .FINE_SHIFT  (FINE_SH)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_o    (busy_o),
    .x_pos_q8_i(x_pos_q8_i),
    .row_i     (row_i),
    .valid_o   (valid_o),
    .density_o (density_o)
  );

  // lattice hash, low byte kept
  function automatic logic [7:0] lattice_hash(input logic [31:0] v);
    logic [31:0] h;
    h = v ^ (v >> 16);
    h = h * tovn_pkg::HASH_MUL_A;
    h = h ^ (h >> 15);
    h = h * tovn_pkg::HASH_MUL_B;
    h = h ^ (h >> 16);
    return h[7:0];
  endfunction

  // q8 smoothstep
  function automatic int ease_curve(input int t);
    return t * t * (768 - 2 * t) / 65536;
  endfunction

  function automatic int corner_value(input int unsigned col, input int unsigned cell_row);
    logic [31:0] key;
    key = col + cell_row * 19;
    return int'({24'd0, lattice_hash(key)});
  endfunction

  // one octave: four corners, vertical blend then horizontal blend
  function automatic int octave_level(input logic [16:0] px, input logic [7:0] y,
                                      input int sh);
    int unsigned col, mask, cell_row, span;
    int fy, fx, tl, bl, tr, br, left, right;
    col      = 32'(px) >> (sh + 8);
    mask     = (256 >> sh) - 1;
    cell_row = 32'(y) >> sh;
    span     = 1 << sh;
    fy    = ease_curve(int'(((32'(y) & (span - 1)) * 256) / span));
    tl    = corner_value(col & mask, cell_row);
    bl    = corner_value(col & mask, cell_row + 1);
    tr    = corner_value((col + 1) & mask, cell_row);
    br    = corner_value((col + 1) & mask, cell_row + 1);
    left  = tl + (bl - tl) * fy / 256;
    right = tr + (br - tr) * fy / 256;
    fx    = ease_curve(int'((32'(px) >> sh) & 32'd255));
    return left + (right - left) * fx / 256;
  endfunction

  function automatic logic [7:0] density_of(input logic [16:0] px, input logic [7:0] y);
    int coarse, fine, d;
    coarse = octave_level(px, y, COARSE_SH);
    fine   = octave_level(px, y, FINE_SH);
    d      = (3 * coarse + fine) / 4;
    return 8'(d);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic add_pixel(input logic [16:0] x, input logic [7:0] row,
                           input int unsigned gap_pct, input bit drain);
    pixel_req_t r;
    r.x = x;
    r.row = row;
    r.gap_pct = gap_pct;
    r.drain = drain;
    pending_pixels.push_back(r);
  endtask

  // random pixel, biased toward cell edges part of the time
  task automatic add_random_pixel(input int unsigned gap_pct, input bit drain);
    logic [16:0] x;
    logic [7:0]  row;
    x   = 17'($urandom_range(131071));
    row = 8'($urandom_range(255));
    if ($urandom_range(3) == 0) x = $urandom_range(1) ? (x | 17'h1fff) : (x & ~17'h1fff);
    if ($urandom_range(3) == 0) row = $urandom_range(1) ? (row | 8'h1f) : (row & ~8'h1f);
    add_pixel(x, row, gap_pct, drain);
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // driver: next request on the falling edge
  always @(negedge clk_i) begin
    pixel_req_t head;
    bit fire;
    fire = 1'b0;
    if (!rst_ni) begin
      fire = 1'b0;
    end else if (start_i && !req_taken) begin
      fire = 1'b1;
    end else if (pending_pixels.size() != 0) begin
      head = pending_pixels[0];
      if (head.drain && expected_density.size() != 0) begin
        fire = 1'b0;
      end else if (!head.drain && $urandom_range(99) < head.gap_pct) begin
        fire = 1'b0;
      end else begin
        void'(pending_pixels.pop_front());
        x_pos_q8_i <= head.x;
        row_i      <= head.row;
        fire = 1'b1;
      end
    end
    start_i <= fire;
  end

  // monitor: predict on accept, check on strobe
  always @(posedge clk_i) begin
    density_exp_t got;
    density_exp_t want;
    if (!rst_ni) begin
      req_taken <= 1'b0;
    end else begin
      if (valid_o === 1'bx) begin
        report_mismatch("valid_o unknown");
      end else if (valid_o) begin
        if (expected_density.size() == 0) begin
          report_mismatch($sformatf("density %0d with no request outstanding", density_o));
        end else begin
          got = expected_density.pop_front();
          if (density_o !== got.density)
            report_mismatch($sformatf("x=%0d row=%0d density %0d, predicted %0d",
                                      got.x, got.row, density_o, got.density));
        end
      end
      if (start_i && !busy_o) begin
        want.x       = x_pos_q8_i;
        want.row     = row_i;
        want.density = density_of(x_pos_q8_i, row_i);
        expected_density.push_back(want);
      end
      req_taken <= start_i && !busy_o;
    end
  end

  // stimulus and end of run
  initial begin
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    x_pos_q8_i     = '0;
    row_i          = '0;
    mismatch_count = 0;

    // directed: extremes, column wrap, cell edges, blend extremes
    add_pixel(17'd0,      8'd0,   34, 1'b0);
    add_pixel(17'd131071, 8'd255, 34, 1'b0);
    add_pixel(17'd0,      8'd255, 34, 1'b0);
    add_pixel(17'd131071, 8'd0,   34, 1'b0);
    add_pixel(17'd65535,  8'd100, 34, 1'b0);
    add_pixel(17'd65536,  8'd100, 34, 1'b0);
    add_pixel(17'd49151,  8'd31,  34, 1'b0);
    add_pixel(17'd49152,  8'd32,  34, 1'b0);
    add_pixel(17'd8191,   8'd63,  34, 1'b0);
    add_pixel(17'd8192,   8'd64,  34, 1'b0);
    add_pixel(17'd16383,  8'd127, 34, 1'b0);
    add_pixel(17'd16384,  8'd128, 34, 1'b0);
    add_pixel(17'd114688, 8'd223, 34, 1'b0);
    add_pixel(17'd122879, 8'd224, 34, 1'b0);
    add_pixel(17'd128,    8'd16,  34, 1'b0);
    add_pixel(17'd4096,   8'd48,  34, 1'b0);
    add_pixel(17'd98303,  8'd191, 34, 1'b0);
    add_pixel(17'd98304,  8'd192, 34, 1'b0);
    add_pixel(17'h15555,  8'h55,  34, 1'b0);
    add_pixel(17'h0aaaa,  8'haa,  34, 1'b0);

    // sender gaps at a third of the cycles, one full drain midway
    for (int i = 0; i < 350; i++) add_random_pixel(34, i == 175);
    // sender mostly idle, entered after a full drain
    for (int i = 0; i < 350; i++) add_random_pixel(83, i == 0);
    // back to back
    for (int i = 0; i < 300; i++) add_random_pixel(0, i == 0);

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_pixels.size() != 0 || start_i) @(negedge clk_i);
    while (expected_density.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (expected_density.size() != 0)
      report_mismatch($sformatf("%0d predictions never matched", expected_density.size()));
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // run limit
  initial begin
    #500_000;
    $display("FAILURE");
    $finish;
  end

endmodule
